// ===== rtl/ddrev_pkg.sv =====
// Package with the widths and constants of the decimal digit reverser.
`timescale 1ns / 1ps

package ddrev_pkg;

  localparam int IN_WIDTH   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int RES_WIDTH  = 35;
  localparam int ACC_WIDTH  = RES_WIDTH - 1;
  localparam int BCD_DIGITS = (DATA_WIDTH * 30103 + 99999) / 100000;
  localparam int BCD_WIDTH  = 4 * BCD_DIGITS;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

endpackage

// ===== rtl/decimal_digit_reverser.sv =====
// Top level of the decimal digit reverser: bit-serial BCD conversion, then digit-serial rebuild.
// A request runs through the BCD shifter over all DATA_WIDTH bits, then the multiply-by-ten
// accumulator, which takes one decimal digit of the magnitude per step (none for zero).
// A new request is taken only once the last result has moved into the output register, and a
// finished result waits in ST_DELIVER while that register is still occupied.
// The output register lets the next request in while a result still waits to be taken.
// Reset clears the state machine and the output valid flag; the datapath holds no reset.
`timescale 1ns / 1ps

module decimal_digit_reverser import ddrev_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [IN_WIDTH-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [RES_WIDTH-1:0] out_reversed,
  output logic                        out_fits_word
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_CONV    = 4'b0010,
    ST_ACCUM   = 4'b0100,
    ST_DELIVER = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_WIDTH-1:0]    cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0]   mag_r, mag_nxt;
  logic [BCD_WIDTH-1:0]    bcd_r, bcd_nxt;
  logic [BCD_WIDTH-1:0]    bcd_adj;
  logic [ACC_WIDTH-1:0]    acc_r, acc_nxt;
  logic                    neg_r, neg_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [RES_WIDTH-1:0]    out_rev_r, out_rev_nxt;
  logic                    out_fits_r, out_fits_nxt;
  logic [DATA_WIDTH-1:0]   in_word;
  logic [ACC_WIDTH-1:0]    limit;
  logic                    bcd_ok;

  assign in_word   = in_value[DATA_WIDTH-1:0];
  assign limit     = ACC_WIDTH'(1) << (DATA_WIDTH - 1);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_reversed  = out_rev_r;
  assign out_fits_word = out_fits_r;

  always_comb begin
    bcd_ok = 1'b1;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
      if (bcd_r[4*d +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_rev_nxt   = out_rev_r;
    out_fits_nxt  = out_fits_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_word[DATA_WIDTH-1];
          mag_nxt   = in_word[DATA_WIDTH-1] ? (~in_word + DATA_WIDTH'(1)) : in_word;
          bcd_nxt   = '0;
          acc_nxt   = '0;
          cnt_nxt   = CNT_WIDTH'(DATA_WIDTH - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_WIDTH-2:0], mag_r[DATA_WIDTH-1]};
        mag_nxt = {mag_r[DATA_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_WIDTH'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (bcd_r == '0) begin
          state_nxt = ST_DELIVER;
        end else begin
          acc_nxt = (acc_r << 3) + (acc_r << 1) + ACC_WIDTH'(bcd_r[3:0]);
          bcd_nxt = bcd_r >> 4;
        end
      end
      ST_DELIVER: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rev_nxt   = neg_r ? (RES_WIDTH'(0) - RES_WIDTH'(acc_r)) : RES_WIDTH'(acc_r);
          out_fits_nxt  = neg_r ? (acc_r <= limit) : (acc_r < limit);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    out_rev_r  <= out_rev_nxt;
    out_fits_r <= out_fits_nxt;
  end

  // An accepted request always starts the binary-to-BCD conversion.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CONV))
    else $error("request accepted without starting conversion");

  // Every BCD digit stays in range while the shifter and the accumulator run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV || state_r == ST_ACCUM) |-> bcd_ok)
    else $error("BCD digit out of range");

  // A finished result waits while the output register is still occupied.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DELIVER && out_valid_r && !out_ready) |=>
      (state_r == ST_DELIVER && $stable(out_rev_r)))
    else $error("result overwrote a pending output");

  // The fit flag agrees with the sign extension of the result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fits_r) |->
      (out_rev_r[RES_WIDTH-1:DATA_WIDTH-1] == '0 ||
       out_rev_r[RES_WIDTH-1:DATA_WIDTH-1] == '1))
    else $error("fit flag set on a result outside the data width");

endmodule

// ===== test/tb_decimal_digit_reverser.sv =====
// Self-checking testbench for the decimal digit reverser, with a directed table and random requests.
`timescale 1ns / 1ps

module tb_decimal_digit_reverser import ddrev_pkg::*; ();

  localparam int DECIMAL_BASE   = 10;
  localparam int DIRECTED_COUNT = 21;
  localparam int RANDOM_PER_PHASE = 545;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct {
    logic signed [RES_WIDTH-1:0] reversed;
    logic                        fits_word;
  } digit_result_t;

  typedef struct {
    logic [IN_WIDTH-1:0]         value;
    bit                          typed;
    logic signed [RES_WIDTH-1:0] reversed;
    logic                        fits_word;
  } directed_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [IN_WIDTH-1:0]  in_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [RES_WIDTH-1:0] out_reversed;
  logic                        out_fits_word;

  digit_result_t pending_results[$];
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{32'sd0,           1'b1, 35'sd0,           1'b1},
    '{32'sd1,           1'b1, 35'sd1,           1'b1},
    '{-32'sd1,          1'b1, -35'sd1,          1'b1},
    '{32'sd2147483647,  1'b1, 35'sd7463847412,  1'b0},
    '{32'h8000_0000,    1'b1, -35'sd8463847412, 1'b0},
    '{32'h7FFF_FFFE,    1'b0, '0, 1'b0},
    '{32'h8000_0001,    1'b0, '0, 1'b0},
    '{32'sd1000000000,  1'b0, '0, 1'b0},
    '{-32'sd1000000000, 1'b0, '0, 1'b0},
    '{32'sd1463847412,  1'b0, '0, 1'b0},
    '{-32'sd1463847412, 1'b0, '0, 1'b0},
    '{32'sd1563847412,  1'b0, '0, 1'b0},
    '{-32'sd1563847412, 1'b0, '0, 1'b0},
    '{32'sd1999999999,  1'b0, '0, 1'b0},
    '{32'sd123456789,   1'b0, '0, 1'b0},
    '{32'sd10,          1'b0, '0, 1'b0},
    '{-32'sd120,        1'b0, '0, 1'b0},
    '{32'sd9,           1'b0, '0, 1'b0},
    '{32'h5555_5555,    1'b0, '0, 1'b0},
    '{32'hAAAA_AAAA,    1'b0, '0, 1'b0},
    '{32'sd1000000003,  1'b0, '0, 1'b0}
  };

  decimal_digit_reverser dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_reversed (out_reversed),
    .out_fits_word(out_fits_word)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned reverse_digits(input longint unsigned magnitude);
    longint unsigned acc;
    acc = 0;
    while (magnitude != 0) begin
      acc = acc * DECIMAL_BASE + magnitude % DECIMAL_BASE;
      magnitude = magnitude / DECIMAL_BASE;
    end
    return acc;
  endfunction

  function automatic digit_result_t predict_reversal(input logic [IN_WIDTH-1:0] raw);
    logic [DATA_WIDTH-1:0] word;
    logic                  negative;
    longint unsigned       magnitude;
    longint unsigned       digits;
    longint unsigned       sign_limit;
    digit_result_t         result;
    word = raw[DATA_WIDTH-1:0];
    negative = word[DATA_WIDTH-1];
    magnitude = 64'(word);
    if (negative) begin
      magnitude = (64'd1 << DATA_WIDTH) - magnitude;
    end
    digits = reverse_digits(magnitude);
    sign_limit = 64'd1 << (DATA_WIDTH - 1);
    if (negative) begin
      result.reversed = RES_WIDTH'(64'd0 - digits);
      result.fits_word = (digits <= sign_limit);
    end else begin
      result.reversed = RES_WIDTH'(digits);
      result.fits_word = (digits < sign_limit);
    end
    return result;
  endfunction

  function automatic logic [IN_WIDTH-1:0] pick_value();
    logic [IN_WIDTH-1:0] value;
    longint unsigned     target;
    int                  scale;
    case ($urandom_range(5))
      0: return $urandom;
      1: value = $urandom_range(999);
      2: begin
        scale = 1;
        repeat ($urandom_range(5)) scale = scale * DECIMAL_BASE;
        value = $urandom_range(9999) * scale;
      end
      3: begin
        // Magnitudes whose reversal lands right around the signed word limit.
        target = 64'd2147483001 + DECIMAL_BASE * $urandom_range(99);
        value = IN_WIDTH'(reverse_digits(target));
      end
      4: value = $urandom_range(32'd2147483647, 32'd1000000000);
      default: begin
        if ($urandom_range(1)) begin
          return 32'h7FFF_FFFF - $urandom_range(15);
        end
        return 32'h8000_0000 + $urandom_range(15);
      end
    endcase
    if ($urandom_range(1)) begin
      value = -value;
    end
    return value;
  endfunction

  task automatic report_mismatch(input string message);
    $display("MISMATCH at %0t: %s", $realtime, message);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [IN_WIDTH-1:0] value, input digit_result_t expected);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(expected);
  endtask

  always @(posedge clk) begin
    digit_result_t expected;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", out_reversed));
      end else begin
        expected = pending_results.pop_front();
        if (out_reversed !== expected.reversed) begin
          report_mismatch($sformatf("reversed %0d, expected %0d",
                                    out_reversed, expected.reversed));
        end
        if (out_fits_word !== expected.fits_word) begin
          report_mismatch($sformatf("fits_word %0b, expected %0b for reversed %0d",
                                    out_fits_word, expected.fits_word, expected.reversed));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    digit_result_t       expected;
    logic [IN_WIDTH-1:0] value;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 86;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        expected.reversed = directed_rows[i].reversed;
        expected.fits_word = directed_rows[i].fits_word;
      end else begin
        expected = predict_reversal(directed_rows[i].value);
      end
      send_request(directed_rows[i].value, expected);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        value = pick_value();
        send_request(value, predict_reversal(value));
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ddrev_pkg.sv
rtl/decimal_digit_reverser.sv
test/tb_decimal_digit_reverser.sv
